// File: rtl/tnlh_pkg.sv
`timescale 1ns / 1ps
// Types and constants of the two-neighbour lock handshake node.
// No dependencies; imported by two_neighbour_lock_handshake.
package tnlh_pkg;

	// number of nodes in the ring; request origins at or above it are dropped
	localparam int NodeCount = 16;

	// input item kinds
	typedef enum logic [2:0] {
		K_REQUEST   = 3'd0,
		K_GRANT     = 3'd1,
		K_OTHER     = 3'd2,
		K_ALARM     = 3'd3,
		K_START_PRI = 3'd4,
		K_START_ALT = 3'd5
	} kind_t;

	// emitted message kinds
	typedef enum logic [1:0] {
		MK_NONE    = 2'd0,
		MK_GRANT   = 2'd1,
		MK_REQUEST = 2'd2,
		MK_SIGNUP  = 2'd3
	} msg_kind_t;

	// node phases
	typedef enum logic [4:0] {
		P_IDLE      = 5'd0,
		P_LOCKED    = 5'd1,
		P_PRI_REQ   = 5'd2,
		P_PRI_FRONT = 5'd3,
		P_BOTH      = 5'd4,
		P_ALT_REQ   = 5'd6,
		P_ALT_FRONT = 5'd7,
		P_FAIL      = 5'd9,
		P_SUCC      = 5'd10,
		P_PRI_BACK  = 5'd13,
		P_ALT_BACK  = 5'd17
	} phase_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		R_OWN_ID     = 3'd0,
		R_FRONT      = 3'd1,
		R_BACK       = 3'd2,
		R_FRONT_ALT  = 3'd3,
		R_BACK_ALT   = 3'd4,
		R_INIT_EN    = 3'd5,
		R_ONE_DIR    = 3'd6
	} reg_index_t;

	// result slot index and count
	typedef logic [1:0] slot_t;

endpackage

// File: rtl/two_neighbour_lock_handshake.sv
`timescale 1ns / 1ps
// One node of a two-neighbour lock handshake: input register, decode, result register.
// Depends on tnlh_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one event: a lock message
//   (request, grant, other), an alarm tick or a start event. Each event gives
//   one to three results on the output channel (out_valid/out_ready); last
//   marks the final result of an event.
//   Configuration: cfg_write with cfg_index/cfg_data writes one register. The user must
//   write only while no event is in flight; the block itself does not enforce it.
//   Each result goes from the event in the input register into the result register.
//   Throughput: one result per cycle while out_ready is high. Results per event:
//   one for most events, two for a granted request, three for an accepted
//   start.
//   The next event is taken in the same cycle that the last result of the
//   current one moves into the output register.
//   Reset: phase returns to idle, configuration registers and slot counter clear, both channels empty.
//   Stall: when out_ready is low the result holds, the event in the input
//   register waits, and in_ready drops once that register is occupied.
module two_neighbour_lock_handshake
	import tnlh_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_write,
	input  logic [2:0]        cfg_index,
	input  logic [3:0]        cfg_data,
	// event input
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        kind,
	input  logic signed [4:0] origin_node,
	input  logic signed [4:0] session_tag,
	// result output
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        msg_kind,
	output logic [3:0]        target_node,
	output logic [3:0]        session_out,
	output logic              handled,
	output logic              protocol_error,
	output logic              last
);

	// configuration registers
	logic [3:0] own_id_q, front_q, back_q, front_alt_q, back_alt_q;
	logic       init_en_q, one_dir_q;

	// node state
	phase_t phase_q, phase_next;

	// input stage
	logic              valid_s1;
	logic [2:0]        kind_s1;
	logic signed [4:0] origin_s1;
	logic signed [4:0] session_s1;
	slot_t             idx_q;

	// result register
	logic       out_valid_q;
	logic [1:0] msg_kind_q;
	logic [3:0] target_q, session_q;
	logic       handled_q, err_q, last_q;

	// decode
	logic       sess_ok, orig_ok, terminal;
	logic [3:0] orig_id;
	logic [3:0] first_id, second_id;
	logic       has_first, has_second;
	phase_t     to_first, to_second;
	logic       grant_hit, match_first, match_second, grant_bad;
	logic       req_take, pair_diff, use_alt, start_go;
	logic       res_handled, res_err;
	slot_t      res_n;
	logic [1:0] res_mk [3];
	logic [3:0] res_tg [3];
	logic [3:0] res_ss [3];
	logic       out_free, adv, is_last, s1_done;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q    <= '0;
			front_q     <= '0;
			back_q      <= '0;
			front_alt_q <= '0;
			back_alt_q  <= '0;
			init_en_q   <= 1'b0;
			one_dir_q   <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				R_OWN_ID:    own_id_q    <= cfg_data;
				R_FRONT:     front_q     <= cfg_data;
				R_BACK:      back_q      <= cfg_data;
				R_FRONT_ALT: front_alt_q <= cfg_data;
				R_BACK_ALT:  back_alt_q  <= cfg_data;
				R_INIT_EN:   init_en_q   <= cfg_data[0];
				R_ONE_DIR:   one_dir_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// basic field checks
	assign sess_ok  = !session_s1[4];
	assign orig_ok  = !origin_s1[4];
	assign orig_id  = origin_s1[3:0];
	assign terminal = (phase_q == P_FAIL) || (phase_q == P_SUCC);

	// grants awaited in each phase
	always_comb begin
		first_id   = '0;
		second_id  = '0;
		has_first  = 1'b0;
		has_second = 1'b0;
		to_first   = P_BOTH;
		to_second  = P_BOTH;
		case (phase_q)
			P_PRI_REQ: begin
				first_id   = front_q;
				has_first  = 1'b1;
				to_first   = P_PRI_FRONT;
				second_id  = back_q;
				has_second = 1'b1;
				to_second  = P_PRI_BACK;
			end
			P_PRI_FRONT: begin
				first_id  = back_q;
				has_first = 1'b1;
			end
			P_PRI_BACK: begin
				first_id  = front_q;
				has_first = 1'b1;
			end
			P_ALT_REQ: begin
				first_id   = front_alt_q;
				has_first  = 1'b1;
				to_first   = P_ALT_FRONT;
				second_id  = back_alt_q;
				has_second = 1'b1;
				to_second  = P_ALT_BACK;
			end
			P_ALT_FRONT: begin
				first_id  = back_alt_q;
				has_first = 1'b1;
			end
			P_ALT_BACK: begin
				first_id  = front_alt_q;
				has_first = 1'b1;
			end
			default: ;
		endcase
	end

	// grant, request and start qualifiers
	assign grant_hit    = (kind_s1 == K_GRANT) && has_first && sess_ok;
	assign match_first  = orig_ok && (orig_id == first_id);
	assign match_second = has_second && orig_ok && (orig_id == second_id);
	assign grant_bad    = grant_hit && !match_first && !match_second;
	assign req_take     = (phase_q == P_IDLE) && (kind_s1 == K_REQUEST) && sess_ok && orig_ok
		&& (int'(orig_id) < NodeCount);
	assign pair_diff    = (front_q != front_alt_q) || (back_q != back_alt_q);
	assign use_alt      = (kind_s1 == K_START_ALT);
	assign start_go     = (phase_q == P_IDLE) && init_en_q
		&& ((kind_s1 == K_START_PRI) || (use_alt && pair_diff));

	// next phase
	always_comb begin
		phase_next = phase_q;
		case (kind_s1)
			K_REQUEST, K_GRANT, K_OTHER: begin
				if (req_take) begin
					phase_next = P_LOCKED;
				end else if (grant_hit && match_first) begin
					phase_next = to_first;
				end else if (grant_hit && match_second) begin
					phase_next = to_second;
				end
			end
			K_ALARM: begin
				if (one_dir_q && phase_q == P_BOTH) begin
					phase_next = P_SUCC;
				end else if (one_dir_q && phase_q != P_LOCKED) begin
					phase_next = P_FAIL;
				end else begin
					phase_next = P_IDLE;
				end
			end
			K_START_PRI, K_START_ALT: begin
				if (start_go) begin
					phase_next = use_alt ? P_ALT_REQ : P_PRI_REQ;
				end
			end
			default: ;
		endcase
	end

	// result list of the current event
	always_comb begin
		res_handled = 1'b0;
		res_err     = 1'b0;
		res_n       = 2'd1;
		for (int i = 0; i < 3; i++) begin
			res_mk[i] = MK_NONE;
			res_tg[i] = '0;
			res_ss[i] = '0;
		end
		case (kind_s1)
			K_REQUEST, K_GRANT, K_OTHER: begin
				res_handled = !terminal && !grant_bad;
				res_err     = terminal || grant_bad;
				if (req_take) begin
					res_n     = 2'd2;
					res_mk[0] = MK_GRANT;
					res_tg[0] = orig_id;
					res_ss[0] = orig_id;
					res_mk[1] = MK_SIGNUP;
					res_ss[1] = orig_id;
				end
			end
			K_ALARM: begin
				res_handled = 1'b1;
			end
			K_START_PRI, K_START_ALT: begin
				res_handled = start_go;
				if (start_go) begin
					res_n     = 2'd3;
					res_mk[0] = MK_REQUEST;
					res_tg[0] = use_alt ? front_alt_q : front_q;
					res_ss[0] = own_id_q;
					res_mk[1] = MK_REQUEST;
					res_tg[1] = use_alt ? back_alt_q : back_q;
					res_ss[1] = own_id_q;
					res_mk[2] = MK_SIGNUP;
					res_ss[2] = own_id_q;
				end
			end
			default: ;
		endcase
	end

	// flow control
	assign out_free = !out_valid_q || out_ready;
	assign adv      = valid_s1 && out_free;
	assign is_last  = (idx_q == res_n - 2'd1);
	assign s1_done  = adv && is_last;
	assign in_ready = !valid_s1 || s1_done;

	// input stage, slot counter and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
			phase_q  <= P_IDLE;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (s1_done) begin
				idx_q   <= '0;
				phase_q <= phase_next;
			end else if (adv) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// input payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1    <= kind;
			origin_s1  <= origin_node;
			session_s1 <= session_tag;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			msg_kind_q <= res_mk[idx_q];
			target_q   <= res_tg[idx_q];
			session_q  <= res_ss[idx_q];
			handled_q  <= res_handled;
			err_q      <= res_err;
			last_q     <= is_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign msg_kind       = msg_kind_q;
	assign target_node    = target_q;
	assign session_out    = session_q;
	assign handled        = handled_q;
	assign protocol_error = err_q;
	assign last           = last_q;

	// slot counter stays inside the result list
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (idx_q < res_n))
		else $error("result slot beyond result count");

	// slot counter rests at zero between events
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> (idx_q == 2'd0))
		else $error("result slot not cleared");

	// an unfinished event holds its place in the input stage
	a_hold_event: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_done) |=> (valid_s1 && $stable(kind_s1) && $stable(phase_q)))
		else $error("event left input stage early");

	// handled and protocol error never appear together
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(handled_q && err_q))
		else $error("handled and error both set");

endmodule

// File: tb/two_neighbour_lock_handshake_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the two-neighbour lock handshake node.
// Directed and random lock requests are checked against a behavioral copy of the node.
// Depends on tnlh_pkg and two_neighbour_lock_handshake.
module two_neighbour_lock_handshake_tb;
	import tnlh_pkg::*;

	// kind codes that no rule accepts
	localparam logic [2:0] KIND_SPARE_LO = 3'd6;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;
	// cycles with nothing accepted before the run is abandoned
	localparam int IdleLimit = 600;

	typedef struct packed {
		logic [2:0] kind;
		logic [4:0] origin;
		logic [4:0] session;
	} lock_event_t;

	typedef struct packed {
		msg_kind_t  mk;
		logic [3:0] target;
		logic [3:0] session;
		logic       hnd;
		logic       err;
		logic       lst;
	} node_msg_t;

	typedef struct {
		logic [3:0] own;
		logic [3:0] front;
		logic [3:0] back;
		logic [3:0] front_alt;
		logic [3:0] back_alt;
		logic       init_en;
		logic       one_dir;
	} node_setting_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_write = 1'b0;
	logic [2:0]        cfg_index = '0;
	logic [3:0]        cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [2:0]        kind = '0;
	logic signed [4:0] origin_node = '0;
	logic signed [4:0] session_tag = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [1:0]        msg_kind;
	logic [3:0]        target_node;
	logic [3:0]        session_out;
	logic              handled;
	logic              protocol_error;
	logic              last;

	two_neighbour_lock_handshake uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .origin_node(origin_node), .session_tag(session_tag),
		.out_valid(out_valid), .out_ready(out_ready),
		.msg_kind(msg_kind), .target_node(target_node), .session_out(session_out),
		.handled(handled), .protocol_error(protocol_error), .last(last)
	);

	// node state and register copies of the predictor
	phase_t            node_phase = P_IDLE;
	logic signed [4:0] holder = -5'sd1;
	logic [3:0]        cfg_own = '0;
	logic [3:0]        cfg_front = '0;
	logic [3:0]        cfg_back = '0;
	logic [3:0]        cfg_front_alt = '0;
	logic [3:0]        cfg_back_alt = '0;
	logic              cfg_init_en = 1'b0;
	logic              cfg_one_dir = 1'b0;

	lock_event_t pending_events [$];
	node_msg_t   expected_msgs [$];
	int queued_count = 0;
	int events_offered = 0;
	int events_taken = 0;
	int results_seen = 0;
	int settings_applied = 0;
	int fail_count = 0;
	int idle_cycles = 0;
	int burst_left = 1;
	int gap_left = 0;
	int sink_mode = 0;
	int sink_timer = 0;
	int sink_count = 0;

	// clock
	initial begin
		forever #10 clk = ~clk;
	end

	function automatic node_msg_t make_msg(msg_kind_t mk, logic [3:0] tgt, logic [3:0] ses);
		node_msg_t m;
		m = '0;
		m.mk = mk;
		m.target = tgt;
		m.session = ses;
		return m;
	endfunction

	// node response to one accepted request, state updated in place
	task automatic step_lock_node(input logic [2:0] k, input logic signed [4:0] org,
	                              input logic signed [4:0] ses);
		node_msg_t msgs [3];
		int n;
		int o;
		int s;
		int first;
		int second;
		phase_t to_first;
		phase_t to_second;
		phase_t next_phase;
		logic hnd;
		logic err;
		logic go;
		logic [3:0] req_front;
		logic [3:0] req_back;
		n = 0;
		o = org;
		s = ses;
		first = -1;
		second = -1;
		to_first = P_IDLE;
		to_second = P_IDLE;
		hnd = 1'b0;
		err = 1'b0;
		if (k <= K_OTHER) begin
			if (node_phase == P_FAIL || node_phase == P_SUCC) begin
				err = 1'b1;
			end else begin
				hnd = 1'b1;
				case (node_phase)
					P_IDLE: begin
						if (k == K_REQUEST && s >= 0 && o < NodeCount) begin
							holder = org;
							if (o >= 0) begin
								msgs[0] = make_msg(MK_GRANT, 4'(o), 4'(o));
								msgs[1] = make_msg(MK_SIGNUP, 4'd0, 4'(o));
								n = 2;
								node_phase = P_LOCKED;
							end
						end
					end
					P_PRI_REQ: begin
						first = cfg_front;
						to_first = P_PRI_FRONT;
						second = cfg_back;
						to_second = P_PRI_BACK;
					end
					P_PRI_FRONT: begin
						first = cfg_back;
						to_first = P_BOTH;
					end
					P_PRI_BACK: begin
						first = cfg_front;
						to_first = P_BOTH;
					end
					P_ALT_REQ: begin
						first = cfg_front_alt;
						to_first = P_ALT_FRONT;
						second = cfg_back_alt;
						to_second = P_ALT_BACK;
					end
					P_ALT_FRONT: begin
						first = cfg_back_alt;
						to_first = P_BOTH;
					end
					P_ALT_BACK: begin
						first = cfg_front_alt;
						to_first = P_BOTH;
					end
					default: begin
					end
				endcase
				// grant collection
				if (k == K_GRANT && first >= 0 && s >= 0) begin
					if (o == first) begin
						node_phase = to_first;
					end else if (second >= 0 && o == second) begin
						node_phase = to_second;
					end else begin
						err = 1'b1;
						hnd = 1'b0;
					end
				end
			end
		end else if (k == K_ALARM) begin
			hnd = 1'b1;
			if (cfg_one_dir && node_phase == P_BOTH) node_phase = P_SUCC;
			else if (cfg_one_dir && node_phase != P_LOCKED) node_phase = P_FAIL;
			else node_phase = P_IDLE;
			holder = -5'sd1;
		end else if (k == K_START_PRI || k == K_START_ALT) begin
			go = 1'b0;
			req_front = cfg_front;
			req_back = cfg_back;
			next_phase = P_PRI_REQ;
			if (node_phase == P_IDLE && cfg_init_en) begin
				if (k == K_START_PRI) begin
					go = 1'b1;
				end else if (cfg_front != cfg_front_alt || cfg_back != cfg_back_alt) begin
					go = 1'b1;
					req_front = cfg_front_alt;
					req_back = cfg_back_alt;
					next_phase = P_ALT_REQ;
				end
			end
			if (go) begin
				hnd = 1'b1;
				msgs[0] = make_msg(MK_REQUEST, req_front, cfg_own);
				msgs[1] = make_msg(MK_REQUEST, req_back, cfg_own);
				msgs[2] = make_msg(MK_SIGNUP, 4'd0, cfg_own);
				n = 3;
				node_phase = next_phase;
				holder = cfg_own;
			end
		end
		// an event with no message still gives one empty result
		if (n == 0) begin
			msgs[0] = make_msg(MK_NONE, 4'd0, 4'd0);
			n = 1;
		end
		for (int i = 0; i < n; i++) begin
			msgs[i].hnd = hnd;
			msgs[i].err = err;
			msgs[i].lst = (i == n - 1);
			expected_msgs.insert(expected_msgs.size(), msgs[i]);
		end
	endtask

	function automatic int field_check(string field, int want, int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			return 1;
		end
		return 0;
	endfunction

	// scoreboard: result check, request prediction, watchdog
	always @(posedge clk) begin : scoreboard
		node_msg_t want;
		int bad;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_msgs.size() == 0) begin
					$error("unexpected result: msg_kind %0d target_node %0d session_out %0d",
					       msg_kind, target_node, session_out);
					fail_count++;
				end else begin
					want = expected_msgs.pop_front();
					bad = field_check("msg_kind", want.mk, msg_kind)
					    + field_check("target_node", want.target, target_node)
					    + field_check("session_out", want.session, session_out)
					    + field_check("handled", want.hnd, handled)
					    + field_check("protocol_error", want.err, protocol_error)
					    + field_check("last", want.lst, last);
					if (bad != 0) fail_count++;
				end
			end
			if (in_valid && in_ready) begin
				step_lock_node(kind, origin_node, session_tag);
				void'(pending_events.pop_front());
				events_taken++;
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("timeout: %0d cycles without progress", idle_cycles);
				$display("[two_neighbour_lock_handshake] ERROR");
				$finish;
			end
		end
	end

	// sender: bursts of requests with random gaps
	always @(negedge clk) begin : event_driver
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && events_taken < events_offered) begin
			// current request not yet taken, hold it
		end else if (gap_left > 0) begin
			in_valid <= 1'b0;
			gap_left--;
		end else if (pending_events.size() != 0) begin
			in_valid <= 1'b1;
			kind <= pending_events[0].kind;
			origin_node <= pending_events[0].origin;
			session_tag <= pending_events[0].session;
			events_offered++;
			if (burst_left > 1) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(1, 16);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver: stall pattern switching between a few modes
	always @(negedge clk) begin : result_sink
		logic ready_next;
		if (sink_timer == 0) begin
			sink_mode = $urandom_range(0, 3);
			sink_timer = $urandom_range(20, 80);
		end else begin
			sink_timer--;
		end
		sink_count++;
		case (sink_mode)
			0: ready_next = 1'b1;
			1: ready_next = $urandom_range(0, 1);
			2: ready_next = (sink_count % 4 == 0);
			default: ready_next = ($urandom_range(0, 7) != 0);
		endcase
		out_ready <= ready_next;
	end

	task automatic push_event(input logic [2:0] k, input int o, input int s);
		lock_event_t ev;
		ev.kind = k;
		ev.origin = 5'(o);
		ev.session = 5'(s);
		pending_events.insert(pending_events.size(), ev);
		queued_count++;
	endtask

	function automatic int any_field();
		return $urandom_range(0, 31) - 16;
	endfunction

	function automatic int grant_session();
		return ($urandom_range(0, 9) == 0) ? -1 : $urandom_range(0, 15);
	endfunction

	task automatic push_noise();
		int o;
		o = ($urandom_range(0, 3) == 0) ? any_field() : $urandom_range(0, 15);
		push_event(3'($urandom_range(0, 7)), o, any_field());
	endtask

	task automatic wait_drained();
		while (pending_events.size() != 0 || expected_msgs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register writes, one per cycle, only while the node is drained
	task automatic set_reg(input reg_index_t idx, input logic [3:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			R_OWN_ID:    cfg_own = val;
			R_FRONT:     cfg_front = val;
			R_BACK:      cfg_back = val;
			R_FRONT_ALT: cfg_front_alt = val;
			R_BACK_ALT:  cfg_back_alt = val;
			R_INIT_EN:   cfg_init_en = val[0];
			R_ONE_DIR:   cfg_one_dir = val[0];
			default: begin
			end
		endcase
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic apply_setting(input node_setting_t st);
		set_reg(R_OWN_ID, st.own);
		set_reg(R_FRONT, st.front);
		set_reg(R_BACK, st.back);
		set_reg(R_FRONT_ALT, st.front_alt);
		set_reg(R_BACK_ALT, st.back_alt);
		// upper data bits are don't-care for the flag registers
		set_reg(R_INIT_EN, {3'($urandom), st.init_en});
		set_reg(R_ONE_DIR, {3'($urandom), st.one_dir});
		end_writes();
		settings_applied++;
	endtask

	// leave a failed or success-after-alarm phase: alarm with one-direction off
	task automatic return_to_idle();
		set_reg(R_ONE_DIR, 4'd0);
		end_writes();
		push_event(K_ALARM, any_field(), any_field());
		wait_drained();
	endtask

	// mostly well-formed acquisitions and incoming locks, some noise
	task automatic gen_random_traffic(input int want, output int made);
		int first_count;
		int pick;
		logic use_alt;
		logic swap;
		logic [3:0] nf;
		logic [3:0] nb;
		first_count = queued_count;
		while (queued_count - first_count < want) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				use_alt = $urandom_range(0, 1);
				swap = $urandom_range(0, 1);
				nf = use_alt ? cfg_front_alt : cfg_front;
				nb = use_alt ? cfg_back_alt : cfg_back;
				push_event(use_alt ? K_START_ALT : K_START_PRI, any_field(), any_field());
				for (int g = 0; g < 2; g++) begin
					if ($urandom_range(0, 4) == 0) push_noise();
					if ($urandom_range(0, 5) == 0)
						push_event(K_GRANT, $urandom_range(0, 15), grant_session());
					push_event(K_GRANT, ((g == 0) ^ swap) ? nf : nb, grant_session());
				end
				if ($urandom_range(0, 6) != 0) push_event(K_ALARM, any_field(), any_field());
			end else if (pick < 70) begin
				push_event(K_REQUEST, $urandom_range(0, 15), $urandom_range(0, 15));
				repeat ($urandom_range(0, 2)) push_noise();
				if ($urandom_range(0, 4) != 0) push_event(K_ALARM, any_field(), any_field());
			end else begin
				repeat ($urandom_range(1, 3)) push_noise();
			end
		end
		made = queued_count - first_count;
	endtask

	task automatic run_random_setting(input node_setting_t st, input int total);
		int done;
		int made;
		done = 0;
		while (done < total) begin
			return_to_idle();
			apply_setting(st);
			gen_random_traffic(8, made);
			done += made;
			wait_drained();
		end
	endtask

	// stimulus sequence
	initial begin
		node_setting_t st;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: start refused, negative origin, lock by node zero
		push_event(K_START_PRI, 0, 0);
		push_event(K_REQUEST, -1, 0);
		push_event(K_REQUEST, 0, 0);
		push_event(K_ALARM, 0, 0);
		wait_drained();

		st = '{own: 4'd15, front: 4'd0, back: 4'd15, front_alt: 4'd7, back_alt: 4'd1,
		       init_en: 1'b1, one_dir: 1'b0};
		apply_setting(st);
		// incoming lock and messages while locked
		push_event(K_REQUEST, 15, -1);
		push_event(K_REQUEST, 15, 15);
		push_event(K_REQUEST, 3, 2);
		push_event(K_GRANT, 0, 0);
		push_event(K_OTHER, 4, 4);
		push_event(K_START_PRI, 0, 0);
		push_event(KIND_SPARE_LO, 15, 15);
		push_event(KIND_SPARE_HI, -16, -16);
		push_event(K_ALARM, -1, -1);
		// primary acquisition, back first, with a stray and an outdated grant
		push_event(K_START_PRI, 0, 0);
		push_event(K_GRANT, 5, 0);
		push_event(K_GRANT, 15, -1);
		push_event(K_GRANT, 15, 3);
		push_event(K_GRANT, 15, 3);
		push_event(K_GRANT, 0, 0);
		push_event(K_ALARM, 0, 0);
		// alternate acquisition
		push_event(K_START_ALT, 0, 0);
		push_event(K_GRANT, 1, 9);
		push_event(K_GRANT, 7, 9);
		push_event(K_ALARM, 0, 0);
		wait_drained();

		// one-direction alarms: success after both grants, then failed
		set_reg(R_ONE_DIR, 4'd1);
		end_writes();
		push_event(K_START_PRI, 0, 0);
		push_event(K_GRANT, 15, 15);
		push_event(K_GRANT, 0, 15);
		push_event(K_ALARM, 0, 0);
		push_event(K_REQUEST, 3, 3);
		push_event(K_ALARM, 0, 0);
		push_event(K_GRANT, 0, 0);
		wait_drained();

		// random traffic over several register settings
		st = '{own: 4'($urandom), front: 4'($urandom), back: 4'($urandom),
		       front_alt: 4'($urandom), back_alt: 4'($urandom), init_en: 1'b1, one_dir: 1'b0};
		run_random_setting(st, 16);
		st.front_alt = st.front;
		st.back_alt = st.back;
		run_random_setting(st, 16);
		st = '{own: 4'($urandom), front: 4'($urandom), back: 4'($urandom),
		       front_alt: 4'($urandom), back_alt: 4'($urandom), init_en: 1'b0, one_dir: 1'b1};
		run_random_setting(st, 16);
		st = '{own: 4'd15, front: 4'd15, back: 4'd15, front_alt: 4'd0, back_alt: 4'd0,
		       init_en: 1'b1, one_dir: 1'b1};
		run_random_setting(st, 16);
		st = '{own: 4'd0, front: 4'd0, back: 4'd0, front_alt: 4'd0, back_alt: 4'd15,
		       init_en: 1'b1, one_dir: 1'b1};
		run_random_setting(st, 16);
		st = '{own: 4'($urandom), front: 4'($urandom), back: 4'($urandom),
		       front_alt: 4'($urandom), back_alt: 4'($urandom), init_en: 1'b1, one_dir: 1'b1};
		run_random_setting(st, 16);

		wait_drained();
		repeat (8) @(posedge clk);
		if (expected_msgs.size() != 0 || pending_events.size() != 0) begin
			$error("%0d results still expected at end of run", expected_msgs.size());
			fail_count++;
		end
		$display("run covered %0d lock events and %0d results under %0d register settings",
		         events_taken, results_seen, settings_applied);
		if (fail_count == 0) begin
			$display("[two_neighbour_lock_handshake] OK");
		end else begin
			$display("%0d mismatching results", fail_count);
			$display("[two_neighbour_lock_handshake] ERROR");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/tnlh_pkg.sv
rtl/two_neighbour_lock_handshake.sv
tb/two_neighbour_lock_handshake_tb.sv
